[sv/gnms_pkg.sv]
// Package for the gradient non-maximum suppression block.
// Holds field widths, storage geometry, queue sizing, register indexes and the
// shared transaction types. Depends on nothing.
`default_nettype none

package gnms_pkg;

    // Field widths.
    localparam int MAG_W  = 15;
    localparam int GRAD_W = 16;
    localparam int ROW_W  = 16;
    localparam int COL_W  = 12;
    localparam int CODE_W = 8;

    // Line storage geometry.
    localparam int MAX_COLS = 4096;
    localparam int LB_AW    = $clog2(MAX_COLS);
    localparam int ECOL_W   = LB_AW + 1;
    localparam int LB_W     = 2 * MAG_W;
    localparam int DL_DEPTH = MAX_COLS + 1;
    localparam int DL_AW    = $clog2(DL_DEPTH);
    localparam int DL_W     = 2 * GRAD_W;

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);
    localparam int QLW     = QCW + 1;

    // Decision arithmetic widths.
    localparam int DIFF_W = MAG_W + 1;
    localparam int NGX_W  = GRAD_W + 1;
    localparam int PROD_W = DIFF_W + NGX_W;
    localparam int NUM_W  = PROD_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = ROW_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 1'b1;
    localparam logic [ROW_W-1:0]     ROWS_RESET     = 16'd480;
    localparam logic [ECOL_W-1:0]    COLS_RESET     = 13'd640;

    // Result codes.
    localparam logic [CODE_W-1:0] EDGE_POSSIBLE = 8'd128;
    localparam logic [CODE_W-1:0] EDGE_NONE     = 8'd255;

    // One pixel ready for a decision: its 3x3 magnitudes and its gradients.
    typedef struct packed {
        logic [MAG_W-1:0]         nw;
        logic [MAG_W-1:0]         n;
        logic [MAG_W-1:0]         ne;
        logic [MAG_W-1:0]         w;
        logic [MAG_W-1:0]         m;
        logic [MAG_W-1:0]         e;
        logic [MAG_W-1:0]         sw;
        logic [MAG_W-1:0]         s;
        logic [MAG_W-1:0]         se;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [ROW_W-1:0]         out_row;
        logic [COL_W-1:0]         out_col;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } q_push_t;

    typedef struct packed {
        logic           not_empty;
        logic [QCW-1:0] level;
    } q_stat_t;

endpackage

`default_nettype wire

[sv/gnms_ifs.sv]
// Stream interfaces for the pixel input and the decision output.
// Each carries valid, ready and the payload; widths come from gnms_pkg.
`default_nettype none

interface gnms_pix_if;
    import gnms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MAG_W-1:0]         grad_mag;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;

    modport source (output valid, grad_mag, grad_x, grad_y, input ready);
    modport sink   (input valid, grad_mag, grad_x, grad_y, output ready);
endinterface

interface gnms_res_if;
    import gnms_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [CODE_W-1:0] edge_code;

    modport source (output valid, out_row, out_col, edge_code, input ready);
    modport sink   (input valid, out_row, out_col, edge_code, output ready);
endinterface

`default_nettype wire

[sv/gradient_non_max_suppression.sv]
// Canny non-maximum suppression on a raster pixel stream. The block takes one
// pixel (magnitude and x/y gradients) per clock while the hand-off queue has
// room, and decides the pixel one row up and one column left once its 3x3
// neighborhood is in; only interior pixels (rows 1 to frame_rows-3, columns 1
// to frame_cols-3) give a transaction, with 128 for a possible edge and 255
// otherwise. After the pixel that completes its neighborhood is accepted, its
// decision passes the line buffer read stage, which also loads the hand-off
// queue, then the coefficient, multiply and compare stages. Line storage is a
// 4096-entry magnitude RAM and a 4097-entry gradient delay RAM, with no
// clearing pass after reset. Write frame_rows and frame_cols between frames.
//
// Top level; depends on gnms_pkg, the interfaces, gnms_front, gnms_queue and
// gnms_back.
`default_nettype none

module gradient_non_max_suppression (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    gnms_pix_if.sink                           pix,
    gnms_res_if.source                         res,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gnms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gnms_pkg::CFG_W-1:0]     cfg_wdata
);
    import gnms_pkg::*;

    logic [ROW_W-1:0]  frame_rows_reg;
    logic [ECOL_W-1:0] frame_cols_reg;
    logic [ECOL_W-1:0] eff_cols;
    q_push_t           q_push;
    q_stat_t           q_stat;
    entry_t            q_head;
    logic              q_pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= ROWS_RESET;
            frame_cols_reg <= COLS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_ROWS: frame_rows_reg <= cfg_wdata;
                CFG_FRAME_COLS: frame_cols_reg <= cfg_wdata[ECOL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Column count clamped to one through the line buffer depth.
    always_comb
    begin
        if (frame_cols_reg == '0)
        begin
            eff_cols = ECOL_W'(1);
        end
        else if (frame_cols_reg > ECOL_W'(MAX_COLS))
        begin
            eff_cols = ECOL_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = frame_cols_reg;
        end
    end

    gnms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .frame_rows (frame_rows_reg),
        .eff_cols   (eff_cols),
        .q_stat     (q_stat),
        .q_push     (q_push)
    );

    gnms_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .stat  (q_stat),
        .head  (q_head)
    );

    gnms_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (q_head),
        .pop    (q_pop),
        .res    (res)
    );

endmodule

`default_nettype wire

[sv/gnms_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write to the same address in one cycle return the old data.
`default_nettype none

module gnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/gnms_front.sv]
// Front part: accepts pixels, tracks the raster position, keeps the magnitude
// line buffers, the gradient delay line and the 3x3 window, and queues each
// interior pixel for a decision. Uses gnms_pkg, gnms_pix_if and gnms_ram.
`default_nettype none

module gnms_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    gnms_pix_if.sink                      pix,
    input  wire logic [gnms_pkg::ROW_W-1:0]  frame_rows,
    input  wire logic [gnms_pkg::ECOL_W-1:0] eff_cols,
    input  wire gnms_pkg::q_stat_t        q_stat,
    output gnms_pkg::q_push_t             q_push
);
    import gnms_pkg::*;

    logic                 acc;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [DL_AW-1:0]     wp_reg, wp_next;
    logic [ECOL_W-1:0]    col_inc;
    logic [ROW_W:0]       row_inc;
    logic                 produce;
    logic [DL_AW:0]       rd_sum;
    logic [DL_AW-1:0]     rd_ptr;

    // Second stage: RAM data is back, the window moves and the pixel is queued.
    logic                 b_valid_reg;
    logic                 b_produce_reg;
    logic [MAG_W-1:0]     b_mag_reg;
    logic [ROW_W-1:0]     b_row_reg;
    logic [COL_W-1:0]     b_col_reg;
    logic [LB_AW-1:0]     b_addr_reg;
    logic                 b_byp_reg;
    logic [LB_W-1:0]      b_byp_data_reg;

    logic [LB_W-1:0]      lb_q;
    logic [LB_W-1:0]      lb_word;
    logic [LB_W-1:0]      lb_wdata;
    logic [DL_W-1:0]      dl_q;
    logic [MAG_W-1:0]     top_mag;
    logic [MAG_W-1:0]     mid_mag;

    logic [MAG_W-1:0]     win_reg  [3][3];
    logic [MAG_W-1:0]     win_next [3][3];

    // A pixel may enter when the queue can still take it and the one in flight.
    assign pix.ready = (QLW'(q_stat.level) + QLW'(b_valid_reg)) < QLW'(Q_DEPTH);
    assign acc       = pix.valid && pix.ready;

    // Raster position and the interior test for the pixel one row and column back.
    always_comb
    begin
        col_inc = {1'b0, col_reg} + ECOL_W'(1);
        row_inc = {1'b0, row_reg} + (ROW_W+1)'(1);
        produce = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
               && (({1'b0, row_reg} + (ROW_W+1)'(2)) <= {1'b0, frame_rows})
               && (({1'b0, col_reg} + ECOL_W'(2)) <= eff_cols);
        if (col_inc >= eff_cols)
        begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, frame_rows}) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    // Delay line pointers: the read entry is eff_cols + 1 writes back.
    always_comb
    begin
        rd_sum  = {1'b0, wp_reg} + (DL_AW+1)'(DL_DEPTH - 1) - (DL_AW+1)'(eff_cols);
        rd_ptr  = (rd_sum >= (DL_AW+1)'(DL_DEPTH)) ? DL_AW'(rd_sum - (DL_AW+1)'(DL_DEPTH))
                                                   : rd_sum[DL_AW-1:0];
        wp_next = (wp_reg == DL_AW'(DL_DEPTH - 1)) ? '0 : wp_reg + DL_AW'(1);
    end

    // Line word: upper half is two rows back, lower half is the previous row.
    assign lb_word  = b_byp_reg ? b_byp_data_reg : lb_q;
    assign top_mag  = lb_word[LB_W-1:MAG_W];
    assign mid_mag  = lb_word[MAG_W-1:0];
    assign lb_wdata = {mid_mag, b_mag_reg};

    gnms_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (lb_wdata),
        .rd_en   (acc),
        .rd_addr (col_reg),
        .rd_data (lb_q)
    );

    gnms_ram #(
        .WIDTH (DL_W),
        .DEPTH (DL_DEPTH)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (acc),
        .wr_addr (wp_reg),
        .wr_data ({pix.grad_x, pix.grad_y}),
        .rd_en   (acc),
        .rd_addr (rd_ptr),
        .rd_data (dl_q)
    );

    // Window shifts left and takes the new column on the right.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top_mag;
        win_next[1][2] = mid_mag;
        win_next[2][2] = b_mag_reg;
    end

    // Queue transaction for an interior pixel.
    always_comb
    begin
        q_push.valid        = b_valid_reg && b_produce_reg;
        q_push.data.nw      = win_next[0][0];
        q_push.data.n       = win_next[0][1];
        q_push.data.ne      = win_next[0][2];
        q_push.data.w       = win_next[1][0];
        q_push.data.m       = win_next[1][1];
        q_push.data.e       = win_next[1][2];
        q_push.data.sw      = win_next[2][0];
        q_push.data.s       = win_next[2][1];
        q_push.data.se      = win_next[2][2];
        q_push.data.grad_x  = dl_q[DL_W-1:GRAD_W];
        q_push.data.grad_y  = dl_q[GRAD_W-1:0];
        q_push.data.out_row = b_row_reg;
        q_push.data.out_col = b_col_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            wp_reg      <= '0;
            b_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            b_valid_reg <= acc;
            if (acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                wp_reg  <= wp_next;
            end
            if (b_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    // Payload of the second stage; the bypass covers a read of the entry
    // being written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_produce_reg  <= produce;
            b_mag_reg      <= pix.grad_mag;
            b_row_reg      <= row_reg - ROW_W'(1);
            b_col_reg      <= col_reg - COL_W'(1);
            b_addr_reg     <= col_reg;
            b_byp_reg      <= b_valid_reg && (b_addr_reg == col_reg);
            b_byp_data_reg <= lb_wdata;
        end
    end

endmodule

`default_nettype wire

[sv/gnms_queue.sv]
// Short queue between the front and back parts, in flip-flops.
// Uses gnms_pkg for the entry type and depth.
`default_nettype none

module gnms_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gnms_pkg::q_push_t push,
    input  wire logic              pop,
    output gnms_pkg::q_stat_t      stat,
    output gnms_pkg::entry_t       head
);
    import gnms_pkg::*;

    entry_t         mem_reg [Q_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    assign head           = mem_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.level     = count_reg;
    assign count_next     = count_reg + QCW'(push.valid) - QCW'(pop);

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

[sv/gnms_back.sv]
// Back part: picks the octant of each queued pixel, forms the two exact
// interpolation numerators and registers the edge decision for output.
// Uses gnms_pkg and gnms_res_if.
`default_nettype none

module gnms_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gnms_pkg::q_stat_t q_stat,
    input  wire gnms_pkg::entry_t  head,
    output logic                   pop,
    gnms_res_if.source             res
);
    import gnms_pkg::*;

    logic                     adv;

    // Octant selection on the queue head.
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [NGX_W-1:0]  gsum;
    logic signed [DIFF_W-1:0] a1, b1, a2, b2;

    // Stage one: coefficients.
    logic                     s1_valid_reg;
    logic                     s1_zero_reg;
    logic signed [DIFF_W-1:0] s1_a1_reg, s1_b1_reg, s1_a2_reg, s1_b2_reg;
    logic signed [NGX_W-1:0]  s1_ngx_reg;
    logic signed [GRAD_W-1:0] s1_gy_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;

    // Stage two: products.
    logic                     s2_valid_reg;
    logic                     s2_zero_reg;
    logic signed [PROD_W-1:0] s2_pa1_reg, s2_pb1_reg, s2_pa2_reg, s2_pb2_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic [COL_W-1:0]         s2_col_reg;

    // Sums and decision.
    logic signed [NUM_W-1:0]  num1;
    logic signed [NUM_W-1:0]  num2;
    logic [CODE_W-1:0]        code;

    // Output register.
    logic                     out_valid_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic [CODE_W-1:0]        out_code_reg;

    function automatic logic signed [DIFF_W-1:0] mdiff(
        input logic [MAG_W-1:0] x,
        input logic [MAG_W-1:0] y
    );
        return signed'({1'b0, x}) - signed'({1'b0, y});
    endfunction

    // The whole pipeline moves when the output register is free or taken.
    assign adv = !out_valid_reg || res.ready;
    assign pop = adv && q_stat.not_empty;

    assign gx   = head.grad_x;
    assign gy   = head.grad_y;
    assign gsum = NGX_W'(gx) + NGX_W'(gy);

    // Interpolation coefficients for the eight gradient octants.
    always_comb
    begin
        if (!gx[GRAD_W-1])
        begin
            if (!gy[GRAD_W-1])
            begin
                if (gx >= gy)
                begin
                    a1 = mdiff(head.m, head.w);  b1 = mdiff(head.nw, head.w);
                    a2 = mdiff(head.m, head.e);  b2 = mdiff(head.se, head.e);
                end
                else
                begin
                    a1 = mdiff(head.n, head.nw); b1 = mdiff(head.n, head.m);
                    a2 = mdiff(head.s, head.se); b2 = mdiff(head.s, head.m);
                end
            end
            else
            begin
                if (!gsum[NGX_W-1])
                begin
                    a1 = mdiff(head.m, head.w);  b1 = mdiff(head.w, head.sw);
                    a2 = mdiff(head.m, head.e);  b2 = mdiff(head.e, head.ne);
                end
                else
                begin
                    a1 = mdiff(head.s, head.sw); b1 = mdiff(head.m, head.s);
                    a2 = mdiff(head.n, head.ne); b2 = mdiff(head.m, head.n);
                end
            end
        end
        else
        begin
            if (!gy[GRAD_W-1])
            begin
                if (gsum <= NGX_W'(0))
                begin
                    a1 = mdiff(head.e, head.m);  b1 = mdiff(head.ne, head.e);
                    a2 = mdiff(head.w, head.m);  b2 = mdiff(head.sw, head.w);
                end
                else
                begin
                    a1 = mdiff(head.ne, head.n); b1 = mdiff(head.n, head.m);
                    a2 = mdiff(head.sw, head.s); b2 = mdiff(head.s, head.m);
                end
            end
            else
            begin
                if (gy > gx)
                begin
                    a1 = mdiff(head.e, head.m);  b1 = mdiff(head.e, head.se);
                    a2 = mdiff(head.w, head.m);  b2 = mdiff(head.w, head.nw);
                end
                else
                begin
                    a1 = mdiff(head.se, head.s); b1 = mdiff(head.m, head.s);
                    a2 = mdiff(head.nw, head.n); b2 = mdiff(head.m, head.n);
                end
            end
        end
    end

    // A first sum above zero, a second sum of zero or above, or a zero centre magnitude means no edge.
    always_comb
    begin
        num1 = NUM_W'(s2_pa1_reg) + NUM_W'(s2_pb1_reg);
        num2 = NUM_W'(s2_pa2_reg) + NUM_W'(s2_pb2_reg);
        if (s2_zero_reg || (num1 > NUM_W'(0)) || !num2[NUM_W-1])
        begin
            code = EDGE_NONE;
        end
        else
        begin
            code = EDGE_POSSIBLE;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_row   = out_row_reg;
    assign res.out_col   = out_col_reg;
    assign res.edge_code = out_code_reg;

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_stat.not_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_zero_reg  <= (head.m == '0);
            s1_a1_reg    <= a1;
            s1_b1_reg    <= b1;
            s1_a2_reg    <= a2;
            s1_b2_reg    <= b2;
            s1_ngx_reg   <= -NGX_W'(gx);
            s1_gy_reg    <= gy;
            s1_row_reg   <= head.out_row;
            s1_col_reg   <= head.out_col;

            s2_zero_reg  <= s1_zero_reg;
            s2_pa1_reg   <= PROD_W'(s1_a1_reg) * PROD_W'(s1_ngx_reg);
            s2_pb1_reg   <= PROD_W'(s1_b1_reg) * PROD_W'(s1_gy_reg);
            s2_pa2_reg   <= PROD_W'(s1_a2_reg) * PROD_W'(s1_ngx_reg);
            s2_pb2_reg   <= PROD_W'(s1_b2_reg) * PROD_W'(s1_gy_reg);
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;

            out_row_reg  <= s2_row_reg;
            out_col_reg  <= s2_col_reg;
            out_code_reg <= code;
        end
    end

endmodule

`default_nettype wire

[sv/gnms_checker.sv]
// Port-level checks for the non-maximum suppression block, and the bind that
// attaches them to the top level. Uses gnms_pkg for widths and result codes.
`default_nettype none

module gnms_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [gnms_pkg::ROW_W-1:0]    res_out_row,
    input wire logic [gnms_pkg::COL_W-1:0]    res_out_col,
    input wire logic [gnms_pkg::CODE_W-1:0]   res_edge_code
);
    import gnms_pkg::*;

    // A stalled result transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(res_out_row) && $stable(res_out_col) && $stable(res_edge_code))
        else $error("result payload changed while stalled");

    // Only the two decision codes are ever produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_edge_code == EDGE_POSSIBLE) || (res_edge_code == EDGE_NONE))
        else $error("unknown edge code");

    // Pixels in row zero or column zero are never decided.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_out_row != '0) && (res_out_col != '0))
        else $error("decision issued for a border pixel");

endmodule

bind gradient_non_max_suppression gnms_checker u_gnms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_out_row   (res.out_row),
    .res_out_col   (res.out_col),
    .res_edge_code (res.edge_code)
);

`default_nettype wire
